>>> hw/rtl/rainbow_reduce_index_to_plain_core_macros.svh
// Assertion macros used by the checked datapath module of the reduction core.
`ifndef RAINBOW_REDUCE_INDEX_TO_PLAIN_CORE_MACROS_SVH
`define RAINBOW_REDUCE_INDEX_TO_PLAIN_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RRIP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrip assertion failed");

// Next-cycle implication, disabled while reset is held.
`define RRIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrip assertion failed");

`endif

>>> hw/rtl/rrip_pkg.sv
package rrip_pkg;

    localparam int MAX_LEN       = 16;
    localparam int CHARSET_DEPTH = 256;
    localparam int REDUCE_SHIFT  = 16;

    localparam logic [1:0] CFG_CHARSET_LEN  = 2'd0;
    localparam logic [1:0] CFG_PLAIN_MIN    = 2'd1;
    localparam logic [1:0] CFG_PLAIN_MAX    = 2'd2;
    localparam logic [1:0] CFG_TABLE_INDEX  = 2'd3;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PREP  = 2'd1,
        CMD_HASH  = 2'd2,
        CMD_PLAIN = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_RANGE = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_NOT_PREP  = 3'd3,
        ST_IDX_RANGE = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OUT_ZERO = 2'd0,
        OUT_ACC  = 2'd1,
        OUT_REM  = 2'd2,
        OUT_CHAR = 2'd3
    } out_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      lat;
        logic      cs_init_we;
        logic [7:0] cs_init_addr;
        logic      cs_we;
        logic      clr_prep;
        logic      set_prep;
        logic      prep_start;
        logic      prep_mul;
        logic      prep_add;
        logic      srch_start;
        logic      srch_step;
        logic      srch_take;
        logic      div_start;
        logic      div_sel;
        logic      digit_take;
        logic      out_load;
        status_t   out_status;
        out_kind_t out_kind;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t cmd;
        logic range_bad;
        logic mul_ovf;
        logic add_carry;
        logic below_min;
        logic at_max;
        logic prepared;
        logic idx_too_big;
        logic idx_ge_space;
        logic pos_zero;
        logic div_busy;
        logic out_free;
    } stat_t;

endpackage

>>> hw/rtl/rrip_ram.sv
module rrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/rrip_div.sv
// Restoring divider, one quotient bit per cycle.
module rrip_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        busy,
    output logic [63:0] quot,
    output logic [63:0] rem
);

    logic [6:0]  cnt_reg;
    logic [63:0] n_reg;
    logic [63:0] r_reg;
    logic [63:0] d_reg;
    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;

    assign trial = {r_reg, n_reg[63]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = trial >= {1'b0, d_reg};
    assign busy  = cnt_reg != 7'd0;
    assign quot  = n_reg;
    assign rem   = r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 7'd0;
        end else if (start) begin
            cnt_reg <= 7'd64;
        end else if (busy) begin
            cnt_reg <= cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg <= dividend;
            r_reg <= 64'd0;
            d_reg <= divisor;
        end else if (busy) begin
            r_reg <= ge ? diff[63:0] : trial[63:0];
            n_reg <= {n_reg[62:0], ge};
        end
    end

endmodule

>>> hw/rtl/rrip_datapath.sv
`include "rainbow_reduce_index_to_plain_core_macros.svh"

module rrip_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rrip_pkg::ctrl_t       ctrl,
    output rrip_pkg::stat_t       stat,
    input  logic [175:0]          s_tdata,
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [87:0]           m_tdata,
    output logic [2:0]            m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [30:0]           cfg_wdata
);

    // Configuration and the prepared flag.
    logic [8:0]  cl_reg;
    logic [4:0]  min_reg;
    logic [4:0]  max_reg;
    logic [30:0] ti_reg;
    logic        prepared_reg;

    // Latched input word.
    rrip_pkg::cmd_t cmd_reg;
    logic [7:0]  addr_reg;
    logic [7:0]  byte_reg;
    logic [63:0] idx_reg;
    logic [63:0] hash_reg;
    logic [30:0] cpos_reg;

    // Space table and working registers.
    logic [63:0] space_reg [0:rrip_pkg::MAX_LEN];
    logic [63:0] term_reg;
    logic [63:0] acc_reg;
    logic [63:0] total_reg;
    logic        mul_ovf_reg;
    logic [4:0]  i_reg;
    logic [63:0] x_reg;
    logic [4:0]  len_reg;
    logic [3:0]  pos_reg;

    // Output register.
    logic        m_valid_reg;
    logic [63:0] m_value_reg;
    logic [7:0]  m_char_reg;
    logic [3:0]  m_pos_reg;
    logic [4:0]  m_len_reg;
    logic [2:0]  m_status_reg;
    logic        m_last_reg;

    logic [72:0] prod;
    logic [64:0] psum;
    logic [63:0] hsum;
    logic [63:0] space_rd;
    logic [4:0]  i_prev;
    logic        out_free;
    logic        div_busy;
    logic [63:0] div_quot;
    logic [63:0] div_rem;
    logic [7:0]  cs_rdata;
    logic        cs_we;
    logic [7:0]  cs_waddr;
    logic [7:0]  cs_wdata;

    assign i_prev   = i_reg - 5'd1;
    assign space_rd = space_reg[i_prev];
    assign prod     = 73'(term_reg) * 73'(cl_reg);
    assign psum     = {1'b0, acc_reg} + {1'b0, term_reg};
    assign hsum     = hash_reg + (64'(ti_reg) << rrip_pkg::REDUCE_SHIFT) + 64'(cpos_reg);
    assign out_free = !m_valid_reg || m_tready;

    assign stat.cmd          = cmd_reg;
    assign stat.range_bad    = (min_reg < 5'd1) || (max_reg > 5'(rrip_pkg::MAX_LEN))
                               || (min_reg > max_reg) || (cl_reg < 9'd1)
                               || (cl_reg > 9'(rrip_pkg::CHARSET_DEPTH));
    assign stat.mul_ovf      = mul_ovf_reg;
    assign stat.add_carry    = psum[64];
    assign stat.below_min    = i_reg < min_reg;
    assign stat.at_max       = i_reg == max_reg;
    assign stat.prepared     = prepared_reg;
    assign stat.idx_too_big  = idx_reg >= total_reg;
    assign stat.idx_ge_space = idx_reg >= space_rd;
    assign stat.pos_zero     = pos_reg == 4'd0;
    assign stat.div_busy     = div_busy;
    assign stat.out_free     = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cl_reg       <= 9'(rrip_pkg::CHARSET_DEPTH);
            min_reg      <= 5'd1;
            max_reg      <= 5'd7;
            ti_reg       <= 31'd0;
            prepared_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    rrip_pkg::CFG_CHARSET_LEN: cl_reg  <= cfg_wdata[8:0];
                    rrip_pkg::CFG_PLAIN_MIN:   min_reg <= cfg_wdata[4:0];
                    rrip_pkg::CFG_PLAIN_MAX:   max_reg <= cfg_wdata[4:0];
                    rrip_pkg::CFG_TABLE_INDEX: ti_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cfg_we && cfg_index != rrip_pkg::CFG_TABLE_INDEX) begin
                prepared_reg <= 1'b0;
            end else if (ctrl.clr_prep) begin
                prepared_reg <= 1'b0;
            end else if (ctrl.set_prep) begin
                prepared_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.lat) begin
            cmd_reg  <= rrip_pkg::cmd_t'(s_tuser);
            addr_reg <= s_tdata[7:0];
            byte_reg <= s_tdata[15:8];
            idx_reg  <= s_tdata[79:16];
            hash_reg <= s_tdata[143:80];
            cpos_reg <= s_tdata[174:144];
        end
        if (ctrl.prep_start) begin
            term_reg     <= 64'd1;
            acc_reg      <= 64'd0;
            i_reg        <= 5'd1;
            space_reg[0] <= 64'd0;
        end
        if (ctrl.prep_mul) begin
            term_reg    <= prod[63:0];
            mul_ovf_reg <= |prod[72:64];
        end
        if (ctrl.prep_add) begin
            if (stat.below_min) begin
                space_reg[i_reg] <= 64'd0;
            end else begin
                space_reg[i_reg] <= psum[63:0];
                acc_reg          <= psum[63:0];
                total_reg        <= psum[63:0];
            end
            i_reg <= i_reg + 5'd1;
        end
        if (ctrl.srch_start) begin
            i_reg <= max_reg;
        end
        if (ctrl.srch_step) begin
            i_reg <= i_prev;
        end
        if (ctrl.srch_take) begin
            x_reg   <= idx_reg - space_rd;
            len_reg <= i_reg;
            pos_reg <= i_prev[3:0];
        end
        if (ctrl.digit_take) begin
            x_reg <= div_quot;
        end
        if (ctrl.out_load && ctrl.out_kind == rrip_pkg::OUT_CHAR && pos_reg != 4'd0) begin
            pos_reg <= pos_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            m_status_reg <= ctrl.out_status;
            m_value_reg  <= 64'd0;
            m_char_reg   <= 8'd0;
            m_pos_reg    <= 4'd0;
            m_len_reg    <= 5'd0;
            m_last_reg   <= 1'b1;
            case (ctrl.out_kind)
                rrip_pkg::OUT_ACC: m_value_reg <= acc_reg;
                rrip_pkg::OUT_REM: m_value_reg <= div_rem;
                rrip_pkg::OUT_CHAR: begin
                    m_char_reg <= cs_rdata;
                    m_pos_reg  <= pos_reg;
                    m_len_reg  <= len_reg;
                    m_last_reg <= pos_reg == 4'd0;
                end
                default: m_value_reg <= 64'd0;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_len_reg, m_pos_reg, m_char_reg, m_value_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    assign cs_we    = ctrl.cs_init_we || ctrl.cs_we;
    assign cs_waddr = ctrl.cs_init_we ? ctrl.cs_init_addr : addr_reg;
    assign cs_wdata = ctrl.cs_init_we ? ctrl.cs_init_addr : byte_reg;

    rrip_ram #(
        .WIDTH(8),
        .DEPTH(rrip_pkg::CHARSET_DEPTH)
    ) u_charset (
        .aclk  (aclk),
        .we    (cs_we),
        .waddr (cs_waddr),
        .wdata (cs_wdata),
        .raddr (div_rem[7:0]),
        .rdata (cs_rdata)
    );

    rrip_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.div_start),
        .dividend (ctrl.div_sel ? x_reg : hsum),
        .divisor  (ctrl.div_sel ? {55'd0, cl_reg} : total_reg),
        .busy     (div_busy),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    `RRIP_ASSERT_IMP(a_load_free, aclk, aresetn, ctrl.out_load, out_free)
    `RRIP_ASSERT_NEXT(a_load_valid, aclk, aresetn, ctrl.out_load, m_valid_reg)
    `RRIP_ASSERT_IMP(a_prep_total, aclk, aresetn, prepared_reg, total_reg != 64'd0)

endmodule

>>> hw/rtl/rrip_ctrl.sv
module rrip_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  rrip_pkg::stat_t stat,
    output rrip_pkg::ctrl_t ctrl
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DISP, S_PMUL, S_PADD, S_MODW,
        S_SRCH, S_CDIV, S_CWAIT, S_CEMIT, S_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [7:0]           init_cnt_reg;
    rrip_pkg::status_t    emit_status_reg, emit_status_next;
    rrip_pkg::out_kind_t  emit_kind_reg, emit_kind_next;

    assign s_tready = state_reg == S_IDLE;

    always_comb begin
        ctrl             = '0;
        ctrl.cs_init_addr = init_cnt_reg;
        ctrl.out_status  = emit_status_reg;
        ctrl.out_kind    = emit_kind_reg;
        state_next       = state_reg;
        emit_status_next = emit_status_reg;
        emit_kind_next   = emit_kind_reg;
        case (state_reg)
            S_INIT: begin
                ctrl.cs_init_we = 1'b1;
                if (init_cnt_reg == 8'hFF) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    ctrl.lat   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                emit_status_next = rrip_pkg::ST_OK;
                emit_kind_next   = rrip_pkg::OUT_ZERO;
                state_next       = S_EMIT;
                case (stat.cmd)
                    rrip_pkg::CMD_LOAD: ctrl.cs_we = 1'b1;
                    rrip_pkg::CMD_PREP: begin
                        ctrl.clr_prep = 1'b1;
                        if (stat.range_bad) begin
                            emit_status_next = rrip_pkg::ST_BAD_RANGE;
                        end else begin
                            ctrl.prep_start = 1'b1;
                            state_next      = S_PMUL;
                        end
                    end
                    rrip_pkg::CMD_HASH: begin
                        if (!stat.prepared) begin
                            emit_status_next = rrip_pkg::ST_NOT_PREP;
                        end else begin
                            ctrl.div_start = 1'b1;
                            state_next     = S_MODW;
                        end
                    end
                    default: begin
                        if (!stat.prepared) begin
                            emit_status_next = rrip_pkg::ST_NOT_PREP;
                        end else if (stat.idx_too_big) begin
                            emit_status_next = rrip_pkg::ST_IDX_RANGE;
                        end else begin
                            ctrl.srch_start = 1'b1;
                            state_next      = S_SRCH;
                        end
                    end
                endcase
            end
            S_PMUL: begin
                ctrl.prep_mul = 1'b1;
                state_next    = S_PADD;
            end
            S_PADD: begin
                if (stat.mul_ovf || (!stat.below_min && stat.add_carry)) begin
                    emit_status_next = rrip_pkg::ST_OVERFLOW;
                    state_next       = S_EMIT;
                end else begin
                    ctrl.prep_add = 1'b1;
                    if (stat.at_max) begin
                        ctrl.set_prep    = 1'b1;
                        emit_kind_next   = rrip_pkg::OUT_ACC;
                        state_next       = S_EMIT;
                    end else begin
                        state_next = S_PMUL;
                    end
                end
            end
            S_MODW: begin
                if (!stat.div_busy) begin
                    emit_kind_next = rrip_pkg::OUT_REM;
                    state_next     = S_EMIT;
                end
            end
            S_SRCH: begin
                if (stat.idx_ge_space) begin
                    ctrl.srch_take = 1'b1;
                    state_next     = S_CDIV;
                end else begin
                    ctrl.srch_step = 1'b1;
                end
            end
            S_CDIV: begin
                ctrl.div_start = 1'b1;
                ctrl.div_sel   = 1'b1;
                state_next     = S_CWAIT;
            end
            S_CWAIT: begin
                ctrl.div_sel = 1'b1;
                if (!stat.div_busy) begin
                    ctrl.digit_take = 1'b1;
                    state_next      = S_CEMIT;
                end
            end
            S_CEMIT: begin
                ctrl.out_status = rrip_pkg::ST_OK;
                ctrl.out_kind   = rrip_pkg::OUT_CHAR;
                ctrl.div_sel    = 1'b1;
                if (stat.out_free) begin
                    ctrl.out_load = 1'b1;
                    if (stat.pos_zero) begin
                        state_next = S_IDLE;
                    end else begin
                        ctrl.div_start = 1'b1;
                        state_next     = S_CWAIT;
                    end
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_INIT;
            init_cnt_reg    <= 8'd0;
            emit_status_reg <= rrip_pkg::ST_OK;
            emit_kind_reg   <= rrip_pkg::OUT_ZERO;
        end else begin
            state_reg       <= state_next;
            emit_status_reg <= emit_status_next;
            emit_kind_reg   <= emit_kind_next;
            if (state_reg == S_INIT) begin
                init_cnt_reg <= init_cnt_reg + 8'd1;
            end
        end
    end

endmodule

>>> hw/rtl/rainbow_reduce_index_to_plain_core.sv
// Rainbow-chain reduction core. After reset the block fills all 256 entries of the
// charset memory with its identity contents and accepts no word until that is done;
// configuration writes are taken at any time. It then handles one input word at a time.
// A prepare runs the multiply and add steps of the space table once per plaintext
// length up to the maximum. A hash reduction waits on the bit-serial 64-bit divider.
// An index conversion first searches down from the maximum length for the plaintext
// length, then runs the divider once per character. A finished result word waits in
// the output register while the core carries on with its next character.
module rainbow_reduce_index_to_plain_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata from bit 0: charset_addr(8), charset_byte(8), index_in(64),
    // hash_word(64), chain_pos(31), one zero pad bit.
    input  logic [175:0] s_tdata,
    // s_tuser: command(2).
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata from bit 0: value(64), plain_char(8), char_pos(4), plain_len(5),
    // seven zero pad bits.
    output logic [87:0]  m_tdata,
    // m_tuser: status(3).
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_wdata
);

    rrip_pkg::ctrl_t ctrl;
    rrip_pkg::stat_t stat;

    // The controller sequences each command; the datapath holds the tables and arithmetic.
    rrip_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    rrip_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule
